// ===== sv/cfd_pkg.sv =====
package cfd_pkg;

    // framing characters
    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_HASH = 8'd35;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_ONE  = 8'd49;
    localparam logic [7:0] CH_NINE = 8'd57;

    // register reset value
    localparam logic [15:0] MAX_CHUNK_RESET = 16'd1200;

    // one decoded result
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       message_end;
        logic       frame_error;
    } t_result;

endpackage

// ===== sv/cfd_ifs.sv =====
// received byte channel
interface cfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// decoded result channel
interface cfd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       message_end;
    logic       frame_error;

    modport source (
        output valid, output payload_byte, output payload_valid,
        output message_end, output frame_error, input ready
    );
    modport sink (
        input valid, input payload_byte, input payload_valid,
        input message_end, input frame_error, output ready
    );
endinterface

// chunk size limit write channel
interface cfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_chunk_size;

    modport source (output valid, output max_chunk_size, input ready);
    modport sink (input valid, input max_chunk_size, output ready);
endinterface

// ===== sv/cfd_parser.sv =====
module cfd_parser #(
    parameter int SIZE_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    input  logic [15:0]     i_max_chunk_size,
    output cfd_pkg::t_result o_result
);

    localparam int LW = (SIZE_WIDTH > 16) ? SIZE_WIDTH : 16;
    localparam int CW = (SIZE_WIDTH + 4 > 16) ? SIZE_WIDTH + 4 : 16;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_HASH   = 3'd1,
        PH_FIRST  = 3'd2,
        PH_ENDNL  = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DATA   = 3'd5
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [SIZE_WIDTH-1:0] r_acc, n_acc;
    logic [SIZE_WIDTH-1:0] r_rem, n_rem;

    logic                  w_is_digit;
    logic [3:0]            w_digit;
    logic [LW-1:0]         w_cap;
    logic [LW-1:0]         w_max_ext;
    logic [LW-1:0]         w_limit;
    logic [CW-1:0]         w_limit_c;
    logic [CW-1:0]         w_next_size;
    logic [SIZE_WIDTH-1:0] w_rem_dec;
    logic                  w_err;

    // digit decode
    assign w_is_digit = i_byte inside {[cfd_pkg::CH_ZERO:cfd_pkg::CH_NINE]};
    assign w_digit    = 4'(i_byte - cfd_pkg::CH_ZERO);

    // effective limit: register clipped to the size field range
    assign w_cap     = LW'({SIZE_WIDTH{1'b1}});
    assign w_max_ext = LW'(i_max_chunk_size);
    assign w_limit   = (w_max_ext < w_cap) ? w_max_ext : w_cap;
    assign w_limit_c = CW'(w_limit);

    // size times ten plus the new digit
    assign w_next_size = CW'({r_acc, 3'b000}) + CW'({r_acc, 1'b0}) + CW'(w_digit);

    // payload countdown
    assign w_rem_dec = (r_rem != '0) ? r_rem - 1'b1 : r_rem;

    // one parse step
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_rem    = r_rem;
        w_err    = 1'b0;
        o_result = '0;
        case (r_phase)
            PH_HASH: begin
                if (i_byte == cfd_pkg::CH_HASH) begin
                    n_phase = PH_FIRST;
                end else begin
                    w_err = 1'b1;
                end
            end
            PH_FIRST: begin
                if (i_byte == cfd_pkg::CH_HASH) begin
                    n_phase = PH_ENDNL;
                end else if (i_byte inside {[cfd_pkg::CH_ONE:cfd_pkg::CH_NINE]}) begin
                    n_acc = SIZE_WIDTH'(w_digit);
                    if (CW'(w_digit) > w_limit_c) begin
                        w_err = 1'b1;
                    end else begin
                        n_phase = PH_DIGITS;
                    end
                end else begin
                    w_err = 1'b1;
                end
            end
            PH_ENDNL: begin
                if (i_byte == cfd_pkg::CH_NL) begin
                    o_result.message_end = 1'b1;
                    n_phase = PH_HUNT;
                end else begin
                    w_err = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (w_is_digit) begin
                    if (w_next_size > w_limit_c) begin
                        w_err = 1'b1;
                    end else begin
                        n_acc = w_next_size[SIZE_WIDTH-1:0];
                    end
                end else if (i_byte == cfd_pkg::CH_NL) begin
                    n_rem   = r_acc;
                    n_phase = PH_DATA;
                end else begin
                    w_err = 1'b1;
                end
            end
            PH_DATA: begin
                o_result.payload_byte  = i_byte;
                o_result.payload_valid = 1'b1;
                n_rem = w_rem_dec;
                if (w_rem_dec == '0) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                if (i_byte == cfd_pkg::CH_NL) begin
                    n_phase = PH_HASH;
                end else begin
                    w_err = 1'b1;
                end
            end
        endcase

        // any violation drops back to hunting
        if (w_err) begin
            n_phase = PH_HUNT;
            n_acc   = '0;
            n_rem   = '0;
        end
        o_result.frame_error = w_err;
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

endmodule

// ===== sv/chunked_framing_decoder_top.sv =====
// chunked framing decoder
// i_rx carries one received byte per request; o_res returns exactly one result
// per byte: the payload byte with payload_valid, message_end on the newline that
// closes the end-of-chunks marker, or frame_error on a framing violation or a
// chunk size above the limit. After an error the decoder hunts for a newline.
// i_cfg writes max_chunk_size; write it only while no byte is in flight.
// The limit in force is the smaller of max_chunk_size and 2^SIZE_WIDTH - 1.
// An accepted byte passes through the input register, then one parse step into
// the result register, which drives o_res. Throughput is one byte per cycle
// while o_res is not stalled; the parse state is a small register set updated
// by one step of short logic, so bytes may arrive back to back.
// When the receiver stalls, the result register holds its request and the input
// register takes one more byte; i_rx.ready drops only when both are full.
// Reset (synchronous, active low) empties both registers, returns the parser to
// hunting for a header newline and sets max_chunk_size to 1200.
module chunked_framing_decoder_top #(
    parameter int SIZE_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfd_rx_if.sink    i_rx,
    cfd_cfg_if.sink   i_cfg,
    cfd_res_if.source o_res
);

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_out_vld;
    cfd_pkg::t_result r_out;
    logic [15:0]      r_max;

    logic             w_adv;
    cfd_pkg::t_result w_result;

    // handshake
    assign w_adv       = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_rx.ready  = !r_in_vld || w_adv;
    assign i_cfg.ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= cfd_pkg::MAX_CHUNK_RESET;
        end else if (i_cfg.valid) begin
            r_max <= i_cfg.max_chunk_size;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // parse step
    cfd_parser #(
        .SIZE_WIDTH(SIZE_WIDTH)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_adv),
        .i_byte          (r_in_byte),
        .i_max_chunk_size(r_max),
        .o_result        (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    // result channel
    assign o_res.valid         = r_out_vld;
    assign o_res.payload_byte  = r_out.payload_byte;
    assign o_res.payload_valid = r_out.payload_valid;
    assign o_res.message_end   = r_out.message_end;
    assign o_res.frame_error   = r_out.frame_error;

endmodule

// ===== verif/cfd_checker.sv =====
`timescale 1ns / 1ps

// watches the byte, limit and result channels, decodes each accepted byte
// on its own and compares every returned result in order
module cfd_checker #(
    parameter int SIZE_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cfd_rx_if    i_rx,
    cfd_cfg_if   i_cfg,
    cfd_res_if   i_res,
    output int   o_pending,
    output int   o_fail_count
);

    typedef enum logic [2:0] {
        SCAN_NL,
        SCAN_HASH,
        SIZE_FIRST,
        END_NL,
        SIZE_DIGITS,
        PAYLOAD
    } t_phase;

    t_phase           phase;
    logic [31:0]      size_acc;
    logic [31:0]      remaining;
    logic [15:0]      max_size;
    cfd_pkg::t_result pending_results[$];
    int               fail_total = 0;

    assign o_fail_count = fail_total;

    // one line per mismatch, printing capped to keep the log short
    task automatic report(input string what, input int got, input int want);
        if (fail_total < 20) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
        fail_total++;
    endtask

    // advance the framing parser by one byte and return its result
    function automatic cfd_pkg::t_result decode_byte(input logic [7:0] b);
        cfd_pkg::t_result r;
        logic [63:0]      cap;
        logic [63:0]      lim;
        logic [63:0]      grown;
        r     = '0;
        cap   = (64'd1 << SIZE_WIDTH) - 64'd1;
        lim   = (64'(max_size) < cap) ? 64'(max_size) : cap;
        case (phase)
            SCAN_HASH: begin
                if (b == cfd_pkg::CH_HASH) phase = SIZE_FIRST;
                else r.frame_error = 1'b1;
            end
            SIZE_FIRST: begin
                if (b == cfd_pkg::CH_HASH) begin
                    phase = END_NL;
                end else if (b >= cfd_pkg::CH_ONE && b <= cfd_pkg::CH_NINE) begin
                    size_acc = 32'(b - cfd_pkg::CH_ZERO);
                    if (64'(size_acc) > lim) r.frame_error = 1'b1;
                    else phase = SIZE_DIGITS;
                end else begin
                    r.frame_error = 1'b1;
                end
            end
            END_NL: begin
                if (b == cfd_pkg::CH_NL) begin
                    r.message_end = 1'b1;
                    phase = SCAN_NL;
                end else begin
                    r.frame_error = 1'b1;
                end
            end
            SIZE_DIGITS: begin
                if (b >= cfd_pkg::CH_ZERO && b <= cfd_pkg::CH_NINE) begin
                    grown = 64'(size_acc) * 64'd10 + 64'(b - cfd_pkg::CH_ZERO);
                    if (grown > lim) r.frame_error = 1'b1;
                    else size_acc = grown[31:0];
                end else if (b == cfd_pkg::CH_NL) begin
                    remaining = size_acc;
                    phase = PAYLOAD;
                end else begin
                    r.frame_error = 1'b1;
                end
            end
            PAYLOAD: begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                if (remaining > 0) remaining--;
                if (remaining == 0) phase = SCAN_NL;
            end
            default: begin
                if (b == cfd_pkg::CH_NL) phase = SCAN_HASH;
                else r.frame_error = 1'b1;
            end
        endcase
        // any violation drops back to hunting for a header newline
        if (r.frame_error) begin
            phase     = SCAN_NL;
            size_acc  = '0;
            remaining = '0;
        end
        return r;
    endfunction

    // track limit writes and bytes, compare results against the oldest prediction
    always @(posedge i_clk) begin
        cfd_pkg::t_result got;
        cfd_pkg::t_result want;
        if (!i_rst_n) begin
            phase     = SCAN_NL;
            size_acc  = '0;
            remaining = '0;
            max_size  = cfd_pkg::MAX_CHUNK_RESET;
            pending_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) max_size = i_cfg.max_chunk_size;
            if (i_rx.valid && i_rx.ready) pending_results.push_back(decode_byte(i_rx.rx_byte));
            if (i_res.valid && i_res.ready) begin
                got.payload_byte  = i_res.payload_byte;
                got.payload_valid = i_res.payload_valid;
                got.message_end   = i_res.message_end;
                got.frame_error   = i_res.frame_error;
                if (pending_results.size() == 0) begin
                    report("result with no byte outstanding", int'(got), -1);
                end else begin
                    want = pending_results.pop_front();
                    if (got.payload_byte != want.payload_byte)
                        report("payload_byte", got.payload_byte, want.payload_byte);
                    if (got.payload_valid != want.payload_valid)
                        report("payload_valid", got.payload_valid, want.payload_valid);
                    if (got.message_end != want.message_end)
                        report("message_end", got.message_end, want.message_end);
                    if (got.frame_error != want.frame_error)
                        report("frame_error", got.frame_error, want.frame_error);
                end
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

// ===== verif/chunked_framing_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module chunked_framing_decoder_top_tb;

    localparam int SIZE_WIDTH  = 16;
    localparam int PHASE_BYTES = 90;
    localparam int NUM_LIMITS  = 7;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       calm = 1'b0;
    int         pending;
    int         fail_count;
    int         n_bytes = 0;
    int         n_messages = 0;
    logic [7:0] byte_q[$];

    cfd_rx_if  rx_if ();
    cfd_cfg_if cfg_if ();
    cfd_res_if res_if ();

    chunked_framing_decoder_top #(
        .SIZE_WIDTH(SIZE_WIDTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .i_cfg  (cfg_if),
        .o_res  (res_if)
    );

    cfd_checker #(
        .SIZE_WIDTH(SIZE_WIDTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_if),
        .i_cfg       (cfg_if),
        .i_res       (res_if),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    always #5 i_clk = ~i_clk;

    // hard stop in case the design hangs
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side stalls a random number of cycles per request
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
    endtask

    task automatic push_chunk(input int unsigned size);
        push_text($sformatf("\n#%0d\n", size));
        repeat (size) byte_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // mostly short chunks, now and then a longer one
    function automatic int unsigned pick_size(input int unsigned lim);
        int unsigned s;
        if ($urandom_range(0, 7) == 0) return $urandom_range(1, lim < 200 ? lim : 200);
        s = $urandom_range(1, 12);
        return s < lim ? s : lim;
    endfunction

    // complete message: a few chunks, then the end marker
    task automatic push_message(input int unsigned lim);
        int n_chunks;
        n_chunks = (lim == 0) ? 0 : $urandom_range(1, 3);
        repeat (n_chunks) push_chunk(pick_size(lim));
        push_text("\n##\n");
        n_messages++;
    endtask

    // random bytes leaning toward framing characters
    task automatic push_noise();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 4))
                0: byte_q.push_back(cfd_pkg::CH_NL);
                1: byte_q.push_back(cfd_pkg::CH_HASH);
                2: byte_q.push_back(cfd_pkg::CH_ZERO);
                3: byte_q.push_back(cfd_pkg::CH_NINE);
                default: byte_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // headers that violate the framing in one way each
    task automatic push_broken(input int unsigned lim);
        logic [7:0] b;
        case ($urandom_range(0, 6))
            0: push_text("\n#0");
            1: begin
                do b = 8'($urandom_range(0, 255));
                while ((b >= cfd_pkg::CH_ZERO && b <= cfd_pkg::CH_NINE) || b == cfd_pkg::CH_NL);
                push_text($sformatf("\n#%0d", $urandom_range(1, 9)));
                byte_q.push_back(b);
            end
            2: push_text("\n#\n");
            3: begin
                do b = 8'($urandom_range(0, 255)); while (b == cfd_pkg::CH_HASH);
                byte_q.push_back(cfd_pkg::CH_NL);
                byte_q.push_back(b);
            end
            4: begin
                do b = 8'($urandom_range(0, 255)); while (b == cfd_pkg::CH_NL);
                push_text("\n##");
                byte_q.push_back(b);
            end
            5: push_text($sformatf("\n#%0d", lim + 1));
            default: push_text($sformatf("\n#%0d0", lim));
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        n_bytes++;
    endtask

    task automatic send_queue();
        while (byte_q.size() > 0) send_byte(byte_q.pop_front());
    endtask

    // hold off new bytes until every result has come back
    task automatic drain();
        rx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_if.valid          <= 1'b1;
        cfg_if.max_chunk_size <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] limits [NUM_LIMITS];
        int          stop_at;
        int unsigned lim;
        int          kind;

        i_rst_n               <= 1'b0;
        rx_if.valid           <= 1'b0;
        rx_if.rx_byte         <= '0;
        cfg_if.valid          <= 1'b0;
        cfg_if.max_chunk_size <= '0;
        res_if.ready          <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases under the reset limit
        push_text("\n##\n");      // empty message
        push_text("\n#2\n");      // two payload bytes at the extremes
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);  // stray byte while hunting
        push_text("\nA");         // missing hash
        push_text("\n#0");        // leading zero
        push_text("\n#\n");       // empty size
        push_text("\n#1a");       // non-digit in size
        push_text("\n##x");       // end marker not closed by a newline
        push_text("\n#1201");     // one above the limit
        send_queue();

        // random traffic under a series of limits, extremes included
        limits = '{cfd_pkg::MAX_CHUNK_RESET, 16'd1, 16'd9, 16'hFFFF, 16'd0,
                   16'($urandom_range(1, 65535)), 16'd50};
        for (int k = 0; k < NUM_LIMITS; k++) begin
            drain();
            write_limit(limits[k]);
            lim     = limits[k];
            stop_at = n_bytes + PHASE_BYTES;
            while (n_bytes < stop_at) begin
                calm = ($urandom_range(0, 7) == 0);
                kind = $urandom_range(0, 9);
                if (kind <= 5) push_message(lim);
                else if (kind == 6) push_noise();
                else if (kind <= 8) push_broken(lim);
                else if (lim > 0 && lim <= 64) push_chunk(lim);
                else push_message(lim);
                send_queue();
            end
        end
        calm = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);

        $display("decoded %0d bytes, %0d complete messages, under %0d size limits",
                 n_bytes, n_messages, NUM_LIMITS);
        $display("framing errors, oversize headers and noise mixed in with random stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
